FILE: sv/positional_list_store_assert.svh
// Assertion macros for the positional list store.
// Expects aclk and aresetn in the scope where the macros are used.
`ifndef POSITIONAL_LIST_STORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define PLS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define PLS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/pls_pkg.sv
// Shared types and constants for the positional list store.
// Used by pls_ctrl, pls_datapath and positional_list_store; no dependencies.
`timescale 1ns / 1ps

package pls_pkg;

    localparam int DEF_CAPACITY = 1024;
    localparam int ACT_W        = 3;
    localparam int POS_W        = 16;
    localparam int VAL_W        = 32;
    localparam int S_TDATA_W    = 48;   // position + item_value, byte aligned

    localparam logic [VAL_W-1:0] NOT_FOUND_VALUE = '1;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_READ     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INS_HEAD = 3'd1;
    localparam logic [ACT_W-1:0] ACT_INS_TAIL = 3'd2;
    localparam logic [ACT_W-1:0] ACT_INS_AT   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DELETE   = 3'd4;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_LOAD_TOP,
        PTR_LOAD_POS,
        PTR_LOAD_POSP1,
        PTR_DEC,
        PTR_INC
    } ptr_op_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_SHIFT_UP,
        WR_SHIFT_DN,
        WR_PLACE
    } wr_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    // Controller -> datapath
    typedef struct packed {
        logic    item_load;
        logic    flag_load;
        logic    res_load;
        ptr_op_t ptr_op;
        wr_op_t  wr_op;
        cnt_op_t cnt_op;
    } pls_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic read_hit;
        logic ins_ok;
        logic ins_shift;
        logic del_ok;
        logic del_shift;
        logic ptr_at_target;
        logic ptr_at_last;
        logic out_free;
    } pls_status_t;

endpackage

FILE: sv/pls_ctrl.sv
// Sequencing controller for the positional list store.
// Depends on pls_pkg; drives pls_datapath through pls_cmd_t.
`timescale 1ns / 1ps

module pls_ctrl import pls_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  pls_status_t status,
    output pls_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SHIFT_UP,
        ST_PLACE,
        ST_SHIFT_DN,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    // Next state and command decode
    always_comb begin
        state_next    = state_reg;
        cmd.item_load = 1'b0;
        cmd.flag_load = 1'b0;
        cmd.res_load  = 1'b0;
        cmd.ptr_op    = PTR_HOLD;
        cmd.wr_op     = WR_NONE;
        cmd.cnt_op    = CNT_HOLD;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.item_load = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.flag_load = 1'b1;
                state_next    = ST_DONE;
                if (status.read_hit) begin
                    cmd.ptr_op = PTR_LOAD_POS;
                end else if (status.ins_ok) begin
                    if (status.ins_shift) begin
                        cmd.ptr_op = PTR_LOAD_TOP;
                        state_next = ST_SHIFT_UP;
                    end else begin
                        cmd.wr_op  = WR_PLACE;
                        cmd.cnt_op = CNT_INC;
                    end
                end else if (status.del_ok) begin
                    if (status.del_shift) begin
                        cmd.ptr_op = PTR_LOAD_POSP1;
                        state_next = ST_SHIFT_DN;
                    end else begin
                        cmd.cnt_op = CNT_DEC;
                    end
                end
            end
            // Move one entry up per cycle, top down to the target slot
            ST_SHIFT_UP: begin
                cmd.wr_op = WR_SHIFT_UP;
                if (status.ptr_at_target) begin
                    state_next = ST_PLACE;
                end else begin
                    cmd.ptr_op = PTR_DEC;
                end
            end
            ST_PLACE: begin
                cmd.wr_op  = WR_PLACE;
                cmd.cnt_op = CNT_INC;
                state_next = ST_DONE;
            end
            // Move one entry down per cycle, up to the last entry
            ST_SHIFT_DN: begin
                cmd.wr_op = WR_SHIFT_DN;
                if (status.ptr_at_last) begin
                    cmd.cnt_op = CNT_DEC;
                    state_next = ST_DONE;
                end else begin
                    cmd.ptr_op = PTR_INC;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/pls_datapath.sv
// Datapath for the positional list store: entry memory, count, shift pointer,
// range checks and the result register. Depends on pls_pkg.
`timescale 1ns / 1ps

module pls_datapath import pls_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY,
    localparam int AW        = $clog2(CAPACITY),
    localparam int CNT_W     = $clog2(CAPACITY + 1),
    localparam int M_TDATA_W = ((VAL_W + CNT_W + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [S_TDATA_W-1:0]   s_data,
    input  logic [ACT_W-1:0]       s_user,
    input  pls_cmd_t               cmd,
    output pls_status_t            status,
    input  logic                   m_ready,
    output logic                   m_valid,
    output logic [M_TDATA_W-1:0]   m_data,
    output logic [1:0]             m_user
);

    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // Latched transaction
    logic [ACT_W-1:0] act_reg;
    logic [POS_W-1:0] pos_reg;
    logic [VAL_W-1:0] val_reg;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [AW-1:0]    ptr_reg, ptr_next;

    logic [VAL_W-1:0] mem [CAPACITY];
    logic [VAL_W-1:0] rd_data_reg;

    logic found_reg, rej_reg;

    logic             m_valid_reg, m_valid_next;
    logic [VAL_W-1:0] res_val_reg;
    logic [CNT_W-1:0] res_cnt_reg;
    logic             res_found_reg, res_rej_reg;

    logic             pos_neg, pos_in, full, is_ins, rejected_now;
    logic [CMP_W-1:0] pos_ext, posp1_ext, cnt_ext;
    logic [CNT_W-1:0] target_cnt, cnt_m1;
    logic [AW-1:0]    target_idx;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [VAL_W-1:0] wr_data;

    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            pos_reg <= s_data[POS_W-1:0];
            val_reg <= s_data[POS_W +: VAL_W];
            act_reg <= s_user;
        end
    end

    // Range checks against the current count
    always_comb begin
        pos_neg   = pos_reg[POS_W-1];
        pos_ext   = CMP_W'(pos_reg);
        posp1_ext = pos_ext + CMP_W'(1);
        cnt_ext   = CMP_W'(count_reg);
        cnt_m1    = count_reg - CNT_W'(1);
        pos_in    = !pos_neg && (pos_ext < cnt_ext);
        full      = (count_reg == CNT_W'(CAPACITY));
        is_ins    = act_reg inside {ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_AT};

        case (act_reg)
            ACT_INS_HEAD: target_cnt = '0;
            ACT_INS_TAIL: target_cnt = count_reg;
            ACT_INS_AT:   target_cnt = pos_neg ? '0 : CNT_W'(pos_ext);
            default:      target_cnt = '0;
        endcase
        target_idx = target_cnt[AW-1:0];

        status.read_hit  = (act_reg == ACT_READ) && pos_in;
        status.ins_ok    = is_ins && !full &&
                           !((act_reg == ACT_INS_AT) && !pos_neg && (pos_ext > cnt_ext));
        status.ins_shift = (target_cnt < count_reg);
        status.del_ok    = (act_reg == ACT_DELETE) && pos_in;
        status.del_shift = (posp1_ext < cnt_ext);
        status.ptr_at_target = (ptr_reg == target_idx);
        status.ptr_at_last   = (ptr_reg == cnt_m1[AW-1:0]);
        status.out_free      = !m_valid_reg || m_ready;

        rejected_now = (is_ins && !status.ins_ok) ||
                       ((act_reg == ACT_DELETE) && !pos_in);
    end

    // Shift pointer
    always_comb begin
        case (cmd.ptr_op)
            PTR_LOAD_TOP:   ptr_next = cnt_m1[AW-1:0];
            PTR_LOAD_POS:   ptr_next = pos_reg[AW-1:0];
            PTR_LOAD_POSP1: ptr_next = posp1_ext[AW-1:0];
            PTR_DEC:        ptr_next = ptr_reg - AW'(1);
            PTR_INC:        ptr_next = ptr_reg + AW'(1);
            default:        ptr_next = ptr_reg;
        endcase
    end

    // Write port select
    always_comb begin
        wr_en   = 1'b1;
        wr_addr = target_idx;
        wr_data = val_reg;
        case (cmd.wr_op)
            WR_SHIFT_UP: begin
                wr_addr = ptr_reg + AW'(1);
                wr_data = rd_data_reg;
            end
            WR_SHIFT_DN: begin
                wr_addr = ptr_reg - AW'(1);
                wr_data = rd_data_reg;
            end
            WR_PLACE: begin
                wr_addr = target_idx;
                wr_data = val_reg;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Entry memory: one write, one registered read at the next pointer
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[ptr_next];
    end

    always_comb begin
        case (cmd.cnt_op)
            CNT_INC: count_next = count_reg + CNT_W'(1);
            CNT_DEC: count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    assign m_valid_next = cmd.res_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Pointer, flags and result payload
    always_ff @(posedge aclk) begin
        ptr_reg <= ptr_next;
        if (cmd.flag_load) begin
            found_reg <= status.read_hit;
            rej_reg   <= rejected_now;
        end
        if (cmd.res_load) begin
            res_val_reg   <= found_reg ? rd_data_reg : NOT_FOUND_VALUE;
            res_cnt_reg   <= count_reg;
            res_found_reg <= found_reg;
            res_rej_reg   <= rej_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = M_TDATA_W'({res_cnt_reg, res_val_reg});
    assign m_user  = {res_rej_reg, res_found_reg};

endmodule

FILE: sv/positional_list_store.sv
// Positional list store: ordered list of signed 32-bit values, read/insert/delete by position.
// ST_DECODE sends reads, rejected items and edits moving no entry to ST_DONE; an insert moving
// entries runs ST_SHIFT_UP then ST_PLACE, a delete ST_SHIFT_DN, one entry moved per cycle
// over the single write and single read port of the entry memory. ST_DONE loads the result
// once the output is free. One transaction at a time; the next is accepted after that load,
// even while a result waits. Synchronous active-low reset empties the list, not the memory.
`timescale 1ns / 1ps
`include "positional_list_store_assert.svh"

module positional_list_store import pls_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY,
    localparam int CNT_W     = $clog2(CAPACITY + 1),
    localparam int M_TDATA_W = ((VAL_W + CNT_W + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // position[15:0], item_value[47:16]
    input  logic [ACT_W-1:0]     s_axis_tuser,   // action[2:0]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // read_value, entry_count, zero pad
    output logic [1:0]           m_axis_tuser    // found[0], rejected[1]
);

    pls_cmd_t    cmd;
    pls_status_t status;

    // Fields used by the checks
    logic [CNT_W-1:0] m_count;
    logic             s_accept;

    pls_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pls_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_axis_tdata),
        .s_user  (s_axis_tuser),
        .cmd     (cmd),
        .status  (status),
        .m_ready (m_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_data  (m_axis_tdata),
        .m_user  (m_axis_tuser)
    );

    assign m_count  = m_axis_tdata[VAL_W +: CNT_W];
    assign s_accept = s_axis_tvalid && s_axis_tready;

    // Checks
    `PLS_ASSERT_NOW(a_count_bound, m_axis_tvalid, m_count <= CNT_W'(CAPACITY), "count beyond capacity")
    `PLS_ASSERT_NEXT(a_busy_after_accept, s_accept, !s_axis_tready, "accepted while busy")
    `PLS_ASSERT_NOW(a_found_not_rejected, m_axis_tvalid, !(&m_axis_tuser), "found with rejected")

endmodule
